// ===== rtl/bdhr_pkg.sv =====
// ----------------------------------------------------------------------------
// bdhr_pkg
// Shared types and constants for the button debounce / hold / repeat block.
// ----------------------------------------------------------------------------
package bdhr_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_W      = 8;
  localparam int TICK_W     = 16;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [KEY_W-1:0]  RST_BUTTON_CODE     = 8'd0;
  localparam logic [TICK_W-1:0] RST_DETECT_TICKS    = 16'd7;
  localparam logic [TICK_W-1:0] RST_LOCKOUT_TICKS   = 16'd30;
  localparam logic [TICK_W-1:0] RST_HOLD_TICKS      = 16'd300;
  localparam logic [TICK_W-1:0] RST_REPEAT_TICKS    = 16'd65;
  localparam logic [TICK_W-1:0] RST_LONG_HOLD_TICKS = 16'd2000;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_BUTTON_CODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DETECT_TICKS    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOCKOUT_TICKS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_TICKS    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LONG_HOLD_TICKS = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PUSHED   = 2'd1,
    PH_RELEASED = 2'd2
  } phase_t;

  typedef struct packed {
    logic [KEY_W-1:0]  button_code;
    logic [TICK_W-1:0] detect_ticks;
    logic [TICK_W-1:0] lockout_ticks;
    logic [TICK_W-1:0] hold_ticks;
    logic [TICK_W-1:0] repeat_ticks;
    logic [TICK_W-1:0] long_hold_ticks;
  } bdhr_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic div_start;
    logic commit;
  } bdhr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_full;
  } bdhr_sts_t;

endpackage

// ===== rtl/button_debounce_hold_repeat.sv =====
// ----------------------------------------------------------------------------
// button_debounce_hold_repeat
// Debounce one key code, flag press, hold, repeat and very long hold.
// Each accepted tick updates the count, runs through the bit-serial remainder
//   unit while pushed with a nonzero repeat period, and is then committed.
// One item in flight: a new tick is accepted only after the last one commits.
// Reset: synchronous; idle phase, counter and flags cleared, registers default.
// ----------------------------------------------------------------------------
module button_debounce_hold_repeat #(
  parameter int COUNT_BITS = bdhr_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdhr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bdhr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bdhr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bdhr_pkg::KEY_W-1:0]        key_code,
  input  logic                              ack_press,
  input  logic                              ack_repeat,
  input  logic                              set_query,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              press_event,
  output logic                              locked,
  output logic                              query_flag,
  output logic                              hold_flag,
  output logic                              repeat_flag,
  output logic                              long_hold_flag,
  output logic [1:0]                        phase
);
  import bdhr_pkg::*;

  bdhr_cfg_t cfg;
  bdhr_cmd_t cmd;
  bdhr_sts_t sts;

  bdhr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdhr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bdhr_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .key_code       (key_code),
    .ack_press      (ack_press),
    .ack_repeat     (ack_repeat),
    .set_query      (set_query),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .press_event    (press_event),
    .locked         (locked),
    .query_flag     (query_flag),
    .hold_flag      (hold_flag),
    .repeat_flag    (repeat_flag),
    .long_hold_flag (long_hold_flag),
    .phase          (phase)
  );

endmodule

// ===== rtl/bdhr_regs.sv =====
// ----------------------------------------------------------------------------
// bdhr_regs
// APB configuration registers, reset to the default timing values.
// ----------------------------------------------------------------------------
module bdhr_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bdhr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bdhr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bdhr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output bdhr_pkg::bdhr_cfg_t                 cfg
);
  import bdhr_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_code     <= RST_BUTTON_CODE;
      cfg.detect_ticks    <= RST_DETECT_TICKS;
      cfg.lockout_ticks   <= RST_LOCKOUT_TICKS;
      cfg.hold_ticks      <= RST_HOLD_TICKS;
      cfg.repeat_ticks    <= RST_REPEAT_TICKS;
      cfg.long_hold_ticks <= RST_LONG_HOLD_TICKS;
    end else if (wr_en) begin
      case (idx)
        REG_BUTTON_CODE:     cfg.button_code     <= pwdata[KEY_W-1:0];
        REG_DETECT_TICKS:    cfg.detect_ticks    <= pwdata[TICK_W-1:0];
        REG_LOCKOUT_TICKS:   cfg.lockout_ticks   <= pwdata[TICK_W-1:0];
        REG_HOLD_TICKS:      cfg.hold_ticks      <= pwdata[TICK_W-1:0];
        REG_REPEAT_TICKS:    cfg.repeat_ticks    <= pwdata[TICK_W-1:0];
        REG_LONG_HOLD_TICKS: cfg.long_hold_ticks <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BUTTON_CODE:     prdata = APB_DATA_W'(cfg.button_code);
      REG_DETECT_TICKS:    prdata = APB_DATA_W'(cfg.detect_ticks);
      REG_LOCKOUT_TICKS:   prdata = APB_DATA_W'(cfg.lockout_ticks);
      REG_HOLD_TICKS:      prdata = APB_DATA_W'(cfg.hold_ticks);
      REG_REPEAT_TICKS:    prdata = APB_DATA_W'(cfg.repeat_ticks);
      REG_LONG_HOLD_TICKS: prdata = APB_DATA_W'(cfg.long_hold_ticks);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== rtl/bdhr_rem.sv =====
// ----------------------------------------------------------------------------
// bdhr_rem
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bdhr_rem #(
  parameter int COUNT_BITS = bdhr_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [COUNT_BITS-1:0]         dividend,
  input  logic [bdhr_pkg::TICK_W-1:0]   divisor,
  output logic                          done,
  output logic                          rem_zero
);
  import bdhr_pkg::*;

  localparam int STEP_W = $clog2(COUNT_BITS + 1);

  logic [COUNT_BITS-1:0] dvd;
  logic [TICK_W-1:0]     rem;
  logic [STEP_W-1:0]     steps;
  logic                  busy;
  logic [TICK_W:0]       trial;
  logic [TICK_W+1:0]     diff;

  assign trial    = {rem, dvd[COUNT_BITS-1]};
  assign diff     = {1'b0, trial} - {2'b00, divisor};
  assign done     = busy && (steps == STEP_W'(1));
  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(COUNT_BITS);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      // restore when the trial subtraction borrows
      rem <= diff[TICK_W+1] ? trial[TICK_W-1:0] : diff[TICK_W-1:0];
    end
  end

endmodule

// ===== rtl/bdhr_datapath.sv =====
// ----------------------------------------------------------------------------
// bdhr_datapath
// Tick counter, phase and flag registers, remainder unit, result register.
// ----------------------------------------------------------------------------
module bdhr_datapath #(
  parameter int COUNT_BITS = bdhr_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bdhr_pkg::bdhr_cfg_t           cfg,
  input  bdhr_pkg::bdhr_cmd_t           cmd,
  output bdhr_pkg::bdhr_sts_t           sts,
  input  logic [bdhr_pkg::KEY_W-1:0]    key_code,
  input  logic                          ack_press,
  input  logic                          ack_repeat,
  input  logic                          set_query,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          press_event,
  output logic                          locked,
  output logic                          query_flag,
  output logic                          hold_flag,
  output logic                          repeat_flag,
  output logic                          long_hold_flag,
  output logic [1:0]                    phase
);
  import bdhr_pkg::*;

  localparam int CMP_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;

  // architectural state
  phase_t                phase_reg, phase_reg_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic press_bit, press_bit_next;
  logic lock_bit, lock_bit_next;
  logic query_bit, query_bit_next;
  logic hold_bit, hold_bit_next;
  logic repeat_bit, repeat_bit_next;
  logic long_hold_bit, long_hold_bit_next;

  // latched item and intermediate count
  logic [KEY_W-1:0]      key_q;
  logic                  ack_press_q, ack_repeat_q, set_query_q;
  logic [COUNT_BITS-1:0] cnt_new, cnt_tmp, cnt_up;
  logic                  match;
  logic                  div_done, rem_zero;

  logic [CMP_W-1:0] cn_x;
  logic             eq_detect, eq_lockout, eq_hold, ge_long;
  logic             p0, r0, q0;

  assign match  = (key_q == cfg.button_code);
  assign cnt_up = (tick_count == '1) ? tick_count : tick_count + COUNT_BITS'(1);

  always_comb begin
    case (phase_reg)
      PH_PUSHED:   cnt_new = match ? cnt_up : '0;
      PH_RELEASED: cnt_new = match ? tick_count : cnt_up;
      default: begin
        if (match)                cnt_new = cnt_up;
        else if (tick_count != 0) cnt_new = tick_count - COUNT_BITS'(1);
        else                      cnt_new = '0;
      end
    endcase
  end

  assign sts.need_div = (phase_reg == PH_PUSHED) && (cfg.repeat_ticks != '0);
  assign sts.div_done = div_done;
  assign sts.out_full = out_valid;

  bdhr_rem #(.COUNT_BITS(COUNT_BITS)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cnt_new),
    .divisor  (cfg.repeat_ticks),
    .done     (div_done),
    .rem_zero (rem_zero)
  );

  assign cn_x       = CMP_W'(cnt_tmp);
  assign eq_detect  = (cn_x == CMP_W'(cfg.detect_ticks));
  assign eq_lockout = (cn_x == CMP_W'(cfg.lockout_ticks));
  assign eq_hold    = (cn_x == CMP_W'(cfg.hold_ticks));
  assign ge_long    = (cn_x >= CMP_W'(cfg.long_hold_ticks));

  // software bits act before the phase machine
  assign p0 = press_bit & ~ack_press_q;
  assign r0 = repeat_bit & ~ack_repeat_q;
  assign q0 = query_bit | set_query_q;

  always_comb begin
    phase_reg_next     = phase_reg;
    tick_count_next    = cnt_tmp;
    press_bit_next     = p0;
    lock_bit_next      = lock_bit;
    query_bit_next     = q0;
    hold_bit_next      = hold_bit;
    repeat_bit_next    = r0;
    long_hold_bit_next = long_hold_bit;
    case (phase_reg)
      PH_PUSHED: begin
        phase_reg_next     = match ? PH_PUSHED : PH_RELEASED;
        hold_bit_next      = hold_bit | eq_hold;
        repeat_bit_next    = r0 | (hold_bit_next && (cfg.repeat_ticks != '0) && rem_zero);
        long_hold_bit_next = long_hold_bit | ge_long;
      end
      PH_RELEASED: begin
        if (eq_lockout) begin
          phase_reg_next     = PH_IDLE;
          tick_count_next    = '0;
          press_bit_next     = 1'b0;
          lock_bit_next      = 1'b0;
          query_bit_next     = 1'b0;
          hold_bit_next      = 1'b0;
          repeat_bit_next    = 1'b0;
          long_hold_bit_next = 1'b0;
        end
      end
      default: begin
        phase_reg_next = PH_IDLE;
        if (eq_detect) begin
          phase_reg_next  = PH_PUSHED;
          tick_count_next = '0;
          press_bit_next  = 1'b1;
          lock_bit_next   = 1'b1;
        end else if (cnt_tmp == '0) begin
          press_bit_next = 1'b0;
          lock_bit_next  = 1'b0;
          query_bit_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      tick_count    <= '0;
      press_bit     <= 1'b0;
      lock_bit      <= 1'b0;
      query_bit     <= 1'b0;
      hold_bit      <= 1'b0;
      repeat_bit    <= 1'b0;
      long_hold_bit <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.commit) begin
        phase_reg     <= phase_reg_next;
        tick_count    <= tick_count_next;
        press_bit     <= press_bit_next;
        lock_bit      <= lock_bit_next;
        query_bit     <= query_bit_next;
        hold_bit      <= hold_bit_next;
        repeat_bit    <= repeat_bit_next;
        long_hold_bit <= long_hold_bit_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_q        <= key_code;
      ack_press_q  <= ack_press;
      ack_repeat_q <= ack_repeat;
      set_query_q  <= set_query;
    end
    if (cmd.calc) begin
      cnt_tmp <= cnt_new;
    end
    if (cmd.commit) begin
      press_event    <= press_bit_next;
      locked         <= lock_bit_next;
      query_flag     <= query_bit_next;
      hold_flag      <= hold_bit_next;
      repeat_flag    <= repeat_bit_next;
      long_hold_flag <= long_hold_bit_next;
      phase          <= phase_reg_next;
    end
  end

  a_lock_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    lock_bit == (phase_reg != PH_IDLE))
    else $error("lock flag out of step with phase");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (phase_reg == PH_IDLE) |-> (!hold_bit && !long_hold_bit))
    else $error("hold flags set while idle");

  a_commit_fills_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");

endmodule

// ===== rtl/bdhr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdhr_ctrl
// Sequencer: accept a tick, update the count, run the remainder if needed, commit.
// ----------------------------------------------------------------------------
module bdhr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  input  bdhr_pkg::bdhr_sts_t  sts,
  output bdhr_pkg::bdhr_cmd_t  cmd
);
  import bdhr_pkg::*;

  typedef enum logic [1:0] {
    S_IN,
    S_CNT,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free     = !sts.out_full || out_ready;
  assign in_ready      = (state == S_IN);
  assign cmd.accept    = (state == S_IN) && in_valid;
  assign cmd.calc      = (state == S_CNT);
  assign cmd.div_start = (state == S_CNT) && sts.need_div;
  assign cmd.commit    = (state == S_COMMIT) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      case (state)
        S_IN:     if (in_valid) state <= S_CNT;
        S_CNT:    state <= sts.need_div ? S_DIV : S_COMMIT;
        S_DIV:    if (sts.div_done) state <= S_COMMIT;
        S_COMMIT: if (slot_free) state <= S_IN;
        default:  state <= S_IN;
      endcase
    end
  end

  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!sts.out_full || out_ready))
    else $error("commit over an untaken result");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.calc, cmd.commit}))
    else $error("overlapping commands");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_CNT))
    else $error("accepted item not processed");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds one-millisecond key ticks into the debounce / hold / repeat block.
// Register settings change between runs, and the sender and receiver idle in
// several patterns. A scoreboard keeps its own copy of the flag machine and
// checks every result in order. The run ends with one long press that runs
// well past the hold, repeat and very-long-hold points.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bdhr_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SPAN_CAP    = 450;

  typedef struct packed {
    logic       press;
    logic       locked;
    logic       query;
    logic       hold;
    logic       rpt;
    logic       long_hold;
    logic [1:0] ph;
  } tick_flags_t;

  class button_flags_sb;
    logic [KEY_W-1:0]  code;
    logic [TICK_W-1:0] detect_t, lockout_t, hold_t, repeat_t, long_t;
    phase_t            ph;
    logic [TICK_W-1:0] count;
    logic              press_b, lock_b, query_b, hold_b, rep_b, long_b;
    tick_flags_t       flags_due[$];
    int unsigned       n_checked, n_errors, n_hold, n_rep, n_long;

    function new();
      code      = RST_BUTTON_CODE;
      detect_t  = RST_DETECT_TICKS;
      lockout_t = RST_LOCKOUT_TICKS;
      hold_t    = RST_HOLD_TICKS;
      repeat_t  = RST_REPEAT_TICKS;
      long_t    = RST_LONG_HOLD_TICKS;
      ph        = PH_IDLE;
      count     = '0;
      {press_b, lock_b, query_b, hold_b, rep_b, long_b} = 6'b0;
      n_checked = 0;
      n_errors  = 0;
      n_hold    = 0;
      n_rep     = 0;
      n_long    = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
      case (idx)
        REG_BUTTON_CODE:     code      = val[KEY_W-1:0];
        REG_DETECT_TICKS:    detect_t  = val[TICK_W-1:0];
        REG_LOCKOUT_TICKS:   lockout_t = val[TICK_W-1:0];
        REG_HOLD_TICKS:      hold_t    = val[TICK_W-1:0];
        REG_REPEAT_TICKS:    repeat_t  = val[TICK_W-1:0];
        REG_LONG_HOLD_TICKS: long_t    = val[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_mismatch(string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR: %s", msg);
    endfunction

    // Advance the flag machine by one accepted tick and queue its flags.
    function void apply_tick(logic [KEY_W-1:0] key, logic ap, logic ar, logic sq);
      logic        hit;
      tick_flags_t f;
      hit = (key == code);
      if (ap) press_b = 1'b0;
      if (ar) rep_b = 1'b0;
      if (sq) query_b = 1'b1;
      case (ph)
        PH_PUSHED: begin
          if (hit) begin
            if (!(&count)) count = count + 1'b1;
          end else begin
            count = '0;
            ph = PH_RELEASED;
          end
          if (count == hold_t) hold_b = 1'b1;
          if (hold_b && repeat_t != 0 && (count % repeat_t) == 0) rep_b = 1'b1;
          if (count >= long_t) long_b = 1'b1;
        end
        PH_RELEASED: begin
          if (!hit && !(&count)) count = count + 1'b1;
          if (count == lockout_t) begin
            {press_b, lock_b, query_b, hold_b, rep_b, long_b} = 6'b0;
            ph = PH_IDLE;
            count = '0;
          end
        end
        default: begin
          ph = PH_IDLE;
          if (hit) begin
            if (!(&count)) count = count + 1'b1;
          end else if (count != 0) begin
            count = count - 1'b1;
          end
          if (count == detect_t) begin
            press_b = 1'b1;
            lock_b = 1'b1;
            ph = PH_PUSHED;
            count = '0;
          end else if (count == 0) begin
            press_b = 1'b0;
            lock_b = 1'b0;
            query_b = 1'b0;
          end
        end
      endcase
      n_hold += hold_b;
      n_rep  += rep_b;
      n_long += long_b;
      f = '{press_b, lock_b, query_b, hold_b, rep_b, long_b, ph};
      flags_due.push_back(f);
    endfunction

    function string show(tick_flags_t f);
      return $sformatf("press=%b lock=%b query=%b hold=%b rep=%b long=%b phase=%0d",
                       f.press, f.locked, f.query, f.hold, f.rpt, f.long_hold, f.ph);
    endfunction

    function void check_result(tick_flags_t got);
      tick_flags_t want;
      if (flags_due.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: %s", show(got)));
        return;
      end
      want = flags_due.pop_front();
      n_checked++;
      if (got !== want)
        note_mismatch($sformatf("result %0d: expected %s, got %s",
                                n_checked, show(want), show(got)));
    endfunction

    function int unsigned pending();
      return flags_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KEY_W-1:0]      key_code = '0;
  logic                  ack_press = 1'b0;
  logic                  ack_repeat = 1'b0;
  logic                  set_query = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  press_event, locked, query_flag, hold_flag;
  logic                  repeat_flag, long_hold_flag;
  logic [1:0]            phase;

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    n_sent = 0;
  int unsigned    n_settings = 0;
  int unsigned    idle_cycles = 0;
  button_flags_sb sb;

  button_debounce_hold_repeat u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({press_event, locked, query_flag, hold_flag,
                       repeat_flag, long_hold_flag, phase});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL button_debounce_hold_repeat");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic sw_bit();
    return ($urandom_range(5) == 0);
  endfunction

  function automatic logic [KEY_W-1:0] other_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom_range(255));
    if (k == sb.code) k = k ^ (8'h01 << $urandom_range(7));
    return k;
  endfunction

  // Enter and leave just after a falling edge; valid stays up on return.
  task automatic send_tick(input logic [KEY_W-1:0] key, input logic ap, input logic ar,
                           input logic sq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    key_code   <= key;
    ack_press  <= ap;
    ack_repeat <= ar;
    set_query  <= sq;
    do @(posedge clk); while (!in_ready);
    sb.apply_tick(key, ap, ar, sq);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_key(input logic [KEY_W-1:0] key);
    send_tick(key, sw_bit(), sw_bit(), sw_bit());
  endtask

  // Hold off the sender until every queued item has produced its result.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
    logic [APB_DATA_W-1:0] rd, mask;
    mask    = (idx == REG_BUTTON_CODE) ? 32'h0000_00FF : 32'h0000_FFFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if ((rd & mask) !== (val & mask))
      sb.note_mismatch($sformatf("register %0d reads %h, wrote %h", idx, rd, val));
  endtask

  // Bring the machine back to idle with an empty counter under the current
  // settings, so new thresholds do not leave it stranded.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    while ((sb.ph != PH_IDLE || sb.count != 0) && guard < 2000) begin
      send_key(other_key());
      guard++;
    end
  endtask

  task automatic program_regs(input logic [KEY_W-1:0] c, input logic [TICK_W-1:0] d,
                              input logic [TICK_W-1:0] l, input logic [TICK_W-1:0] h,
                              input logic [TICK_W-1:0] r, input logic [TICK_W-1:0] lh);
    settle();
    drain();
    reg_write(REG_BUTTON_CODE, 32'(c));
    reg_write(REG_DETECT_TICKS, 32'(d));
    reg_write(REG_LOCKOUT_TICKS, 32'(l));
    reg_write(REG_HOLD_TICKS, 32'(h));
    reg_write(REG_REPEAT_TICKS, 32'(r));
    reg_write(REG_LONG_HOLD_TICKS, 32'(lh));
    n_settings++;
  endtask

  // Bouncy lead-in, a held press with rare glitches, then a release.
  task automatic press_cycle();
    int unsigned span, n;
    n = $urandom_range(0, 3);
    repeat (n) send_key($urandom_range(1) ? sb.code : other_key());
    span = int'(sb.detect_t) + int'(sb.long_t) + 2 * int'(sb.repeat_t) + 4;
    if (span > SPAN_CAP) span = SPAN_CAP;
    n = $urandom_range(0, span);
    repeat (n) send_key(($urandom_range(19) != 0) ? sb.code : other_key());
    span = int'(sb.lockout_t) + 4;
    if (span > SPAN_CAP) span = SPAN_CAP;
    n = $urandom_range(1, span);
    repeat (n) send_key(($urandom_range(9) != 0) ? other_key() : sb.code);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned start, n;
    start = n_sent;
    while (n_sent - start < target) begin
      if ($urandom_range(4) == 0) begin
        n = $urandom_range(1, 12);
        repeat (n) send_key(KEY_W'($urandom_range(255)));
      end else begin
        press_cycle();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset settings: match on key 0, then a miss clears the query mark
    send_tick(8'h00, 1'b1, 1'b1, 1'b1);
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);

    program_regs(8'hFF, 16'd2, 16'd2, 16'd2, 16'd2, 16'd3);
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0);
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);
    send_tick(8'hFF, 1'b0, 1'b0, 1'b1);
    // acknowledges lose to a repeat point on the same tick
    send_tick(8'hFF, 1'b1, 1'b1, 1'b0);
    send_tick(8'hFF, 1'b0, 1'b1, 1'b0);
    // release after hold: counter 0 is a repeat point
    send_tick(8'h7F, 1'b0, 1'b0, 1'b0);
    // a match while released neither counts nor re-presses
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);
    send_tick(8'h80, 1'b0, 1'b0, 1'b1);
    send_tick(8'h01, 1'b0, 1'b0, 1'b0);

    // zero thresholds and zero repeat period
    program_regs(8'h55, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_tick(8'hAA, 1'b0, 1'b0, 1'b0);
    send_tick(8'h55, 1'b0, 1'b0, 1'b1);
    send_tick(8'hAA, 1'b0, 1'b0, 1'b0);
    send_tick(8'h55, 1'b0, 1'b0, 1'b0);

    program_regs(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick(8'hFF, 1'b1, 1'b1, 1'b1);
    send_tick(8'hFF, 1'b0, 1'b0, 1'b0);
    send_tick(8'hFF, 1'b1, 1'b0, 1'b1);

    for (int p = 0; p < 10; p++) begin
      case (p)
        1: program_regs(8'h00, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        2: program_regs(8'hFF, TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 8)),
                        TICK_W'($urandom_range(1, 10)), TICK_W'($urandom_range(1, 6)),
                        TICK_W'($urandom_range(1, 24)));
        3: program_regs(KEY_W'($urandom_range(255)), 16'd0, TICK_W'($urandom_range(1, 6)),
                        16'd0, 16'd0, 16'd0);
        4: program_regs(KEY_W'($urandom_range(255)), TICK_W'($urandom_range(1, 6)),
                        TICK_W'($urandom_range(1, 8)), 16'd0,
                        TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(0, 12)));
        5: program_regs(KEY_W'($urandom_range(255)), RST_DETECT_TICKS, RST_LOCKOUT_TICKS,
                        RST_HOLD_TICKS, RST_REPEAT_TICKS, RST_LONG_HOLD_TICKS);
        9: program_regs(KEY_W'($urandom_range(255)), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF);
        default: program_regs(KEY_W'($urandom_range(255)), TICK_W'($urandom_range(1, 6)),
                              TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(1, 10)),
                              TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 24)));
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct = 25;
          recv_stall_pct = 25;
        end
      endcase
      run_random((p == 5) ? 400 : (p == 9) ? 60 : 180);
    end

    // hold one press well past the hold, repeat and very-long-hold points
    program_regs(KEY_W'($urandom_range(255)), 16'd2, 16'd3, 16'd40, 16'd9, 16'd150);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) send_key(sb.code);
    repeat (3) send_key(other_key());

    drain();
    repeat (30) @(posedge clk);
    if (sb.pending() != 0)
      sb.note_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Ran %0d key ticks over %0d register settings; %0d results checked, %0d bad.",
             n_sent, n_settings, sb.n_checked, sb.n_errors);
    $display("Ticks with hold/repeat/long-hold set: %0d/%0d/%0d.",
             sb.n_hold, sb.n_rep, sb.n_long);
    if (sb.n_errors == 0) begin
      $display("PASS button_debounce_hold_repeat");
    end else begin
      $display("FAIL button_debounce_hold_repeat");
    end
    $finish;
  end

endmodule

// ===== button_debounce_hold_repeat.f =====
rtl/bdhr_pkg.sv
rtl/bdhr_regs.sv
rtl/bdhr_rem.sv
rtl/bdhr_datapath.sv
rtl/bdhr_ctrl.sv
rtl/button_debounce_hold_repeat.sv
test/testbench.sv
